>>> rtl/heart_rate_beat_detector_macros.svh
// Assertion macros for the heart rate beat detector.
`ifndef HEART_RATE_BEAT_DETECTOR_MACROS_SVH
`define HEART_RATE_BEAT_DETECTOR_MACROS_SVH

// HRBD_ASSERT_IMPL: whenever ante holds at a clock edge, cons must hold too.
// HRBD_ASSERT_NEVER: expr must never hold at a clock edge out of reset.
`ifndef SYNTH
`define HRBD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HRBD_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`else
`define HRBD_ASSERT_IMPL(label, ante, cons, msg)
`define HRBD_ASSERT_NEVER(label, expr, msg)
`endif

`endif

>>> rtl/hrbd_pkg.sv
// Types and constants shared by the heart rate beat detector.
package hrbd_pkg;

  localparam int IR_W      = 18;
  localparam int TS_W      = 32;
  localparam int RATE_W    = 20;
  localparam int MIN_W     = 16;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;

  // 60000 ms per minute with four fraction bits.
  localparam logic [RATE_W-1:0] RATE_SCALE = 20'd960000;

  localparam logic [IR_W-1:0]  PRESENCE_RESET  = 18'd5000;
  localparam logic [IR_W-1:0]  THRESHOLD_RESET = 18'd500;
  localparam logic [MIN_W-1:0] MIN_INT_RESET   = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESENCE     = 2'd0,
    REG_THRESHOLD    = 2'd1,
    REG_MIN_INTERVAL = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_RATE,
    ST_DIV_AVG,
    ST_DONE
  } state_t;

endpackage

>>> rtl/heart_rate_beat_detector.sv
// Heart rate beat detector: slope threshold, serial divider and moving average.
//
// Usage. Each input request carries one 18-bit infrared sample and its 32-bit
// millisecond timestamp; it is taken at a rising edge with in_valid high and
// in_stall low. A sample below the presence level is dropped without effect.
// A kept sample whose rise over the previous kept sample exceeds the beat
// threshold, arriving more than the minimum interval after the last beat,
// yields one output request: the instant rate 960000/dt (beats per minute,
// four fraction bits) and the mean of the rate history ring.
// Timing. A sample without a beat passes through the evaluation state and
// back to idle. A beat runs the bit-serial restoring divider, which delivers
// one quotient bit a cycle, first for the rate and then for the average.
// The result sits in an output register, so the next sample is taken while it
// waits; only a second beat that finishes while the receiver still stalls the
// first holds the block until the output register frees up.
// Reset (synchronous, rst_n low) restores the register defaults and clears the
// previous sample, the last beat time, the history ring and its slot pointer.
// Configuration writes are accepted in any cycle; indices beyond the three
// registers are ignored.

`include "heart_rate_beat_detector_macros.svh"

module heart_rate_beat_detector #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [hrbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hrbd_pkg::CFG_W-1:0]        cfg_data,
  // Sample channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hrbd_pkg::IR_W-1:0]         in_ir_sample,
  input  logic [hrbd_pkg::TS_W-1:0]         in_timestamp_ms,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hrbd_pkg::RATE_W-1:0]       out_beat_rate,
  output logic [hrbd_pkg::RATE_W-1:0]       out_average_rate
);

  localparam int IR_W   = hrbd_pkg::IR_W;
  localparam int TS_W   = hrbd_pkg::TS_W;
  localparam int RATE_W = hrbd_pkg::RATE_W;
  localparam int MIN_W  = hrbd_pkg::MIN_W;
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  // The running sum of the ring needs clog2(depth) bits above one rate.
  localparam int SUM_W  = RATE_W + $clog2(HISTORY_DEPTH);
  // The divider's dividend/quotient register covers both divisions.
  localparam int DIV_W  = SUM_W;
  localparam int CNT_W  = $clog2(DIV_W);

  // Configuration registers.
  logic [IR_W-1:0]  presence_r;
  logic [IR_W-1:0]  threshold_r;
  logic [MIN_W-1:0] min_int_r;

  // Detector state.
  hrbd_pkg::state_t  state_r, state_nxt;
  logic [IR_W-1:0]   prev_ir_r;
  logic [TS_W-1:0]   last_beat_r;
  logic [RATE_W-1:0] history_r [HISTORY_DEPTH];
  logic [SLOT_W-1:0] slot_r;
  logic [SUM_W-1:0]  sum_r;

  // Captured sample.
  logic [IR_W-1:0] ir_r;
  logic [TS_W-1:0] ts_r;

  // Serial divider.
  logic [DIV_W-1:0]  dq_r, dq_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [TS_W-1:0]   dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RATE_W:0]   rem_sh;
  logic [RATE_W:0]   rem_diff;
  logic              rem_ge;

  logic [RATE_W-1:0] rate_r;
  logic [RATE_W-1:0] avg_r;
  logic              out_valid_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [RATE_W-1:0] out_avg_r;

  // Decisions taken on the captured sample.
  logic [IR_W:0]    rise;
  logic [TS_W-1:0]  dt;
  logic             present;
  logic             beat;
  logic [SUM_W-1:0] sum_nxt;
  logic             div_last;
  logic             out_load;
  logic             in_take;

  // -------------------------------------------------------------------------
  // Combinational datapath.
  // -------------------------------------------------------------------------
  always_comb begin
    // The rise is signed, so a falling signal never counts as a beat.
    rise    = {1'b0, ir_r} - {1'b0, prev_ir_r};
    dt      = ts_r - last_beat_r;
    present = (ir_r >= presence_r);
    beat    = !rise[IR_W] && (rise[IR_W-1:0] > threshold_r)
              && (dt > {{(TS_W-MIN_W){1'b0}}, min_int_r});

    // One restoring step: bring down the next dividend bit and try to
    // subtract. The partial remainder always stays below 2^20, so a divisor
    // with any bit set above that is never reached.
    rem_sh   = {rem_r, dq_r[DIV_W-1]};
    rem_diff = rem_sh - dvs_r[RATE_W:0];
    rem_ge   = (dvs_r[TS_W-1:RATE_W+1] == '0) && (rem_sh >= dvs_r[RATE_W:0]);
    rem_nxt  = rem_ge ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
    dq_nxt   = {dq_r[DIV_W-2:0], rem_ge};
    div_last = (cnt_r == '0);

    // Running sum of the ring with the oldest entry replaced by the new rate.
    sum_nxt = sum_r - SUM_W'(history_r[slot_r]) + SUM_W'(dq_nxt[RATE_W-1:0]);
  end

  // -------------------------------------------------------------------------
  // Control: next state.
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrbd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = hrbd_pkg::ST_EVAL;
        end
      end
      hrbd_pkg::ST_EVAL: begin
        state_nxt = (present && beat) ? hrbd_pkg::ST_DIV_RATE : hrbd_pkg::ST_IDLE;
      end
      hrbd_pkg::ST_DIV_RATE: begin
        if (div_last) begin
          state_nxt = hrbd_pkg::ST_DIV_AVG;
        end
      end
      hrbd_pkg::ST_DIV_AVG: begin
        if (div_last) begin
          state_nxt = hrbd_pkg::ST_DONE;
        end
      end
      hrbd_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = hrbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hrbd_pkg::ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Control: outputs of the state machine.
  // -------------------------------------------------------------------------
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state_r)
      hrbd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      hrbd_pkg::ST_DONE: begin
        // The output register frees up when empty or being taken this cycle.
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_take = in_valid && !in_stall;

  // -------------------------------------------------------------------------
  // Control registers.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrbd_pkg::ST_IDLE;
      presence_r  <= hrbd_pkg::PRESENCE_RESET;
      threshold_r <= hrbd_pkg::THRESHOLD_RESET;
      min_int_r   <= hrbd_pkg::MIN_INT_RESET;
      prev_ir_r   <= '0;
      last_beat_r <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          hrbd_pkg::REG_PRESENCE:     presence_r  <= cfg_data[IR_W-1:0];
          hrbd_pkg::REG_THRESHOLD:    threshold_r <= cfg_data[IR_W-1:0];
          hrbd_pkg::REG_MIN_INTERVAL: min_int_r   <= cfg_data[MIN_W-1:0];
          default: begin
          end
        endcase
      end

      // Every kept sample becomes the reference for the next rise.
      if ((state_r == hrbd_pkg::ST_EVAL) && present) begin
        prev_ir_r <= ir_r;
        if (beat) begin
          last_beat_r <= ts_r;
        end
      end

      // The finished rate goes into the ring on the last rate step.
      if ((state_r == hrbd_pkg::ST_DIV_RATE) && div_last) begin
        history_r[slot_r] <= dq_nxt[RATE_W-1:0];
        sum_r             <= sum_nxt;
        slot_r            <= (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Payload registers: sample capture, divider and result.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_r <= in_ir_sample;
      ts_r <= in_timestamp_ms;
    end

    case (state_r)
      hrbd_pkg::ST_EVAL: begin
        dq_r  <= DIV_W'(hrbd_pkg::RATE_SCALE);
        rem_r <= '0;
        dvs_r <= dt;
        cnt_r <= CNT_W'(DIV_W - 1);
      end
      hrbd_pkg::ST_DIV_RATE: begin
        if (div_last) begin
          // Reload for the mean: running sum divided by the ring depth.
          rate_r <= dq_nxt[RATE_W-1:0];
          dq_r   <= DIV_W'(sum_nxt);
          rem_r  <= '0;
          dvs_r  <= TS_W'(HISTORY_DEPTH);
          cnt_r  <= CNT_W'(DIV_W - 1);
        end else begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      hrbd_pkg::ST_DIV_AVG: begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (div_last) begin
          avg_r <= dq_nxt[RATE_W-1:0];
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_rate_r <= rate_r;
      out_avg_r  <= avg_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_beat_rate    = out_rate_r;
  assign out_average_rate = out_avg_r;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `HRBD_ASSERT_IMPL(a_out_from_done, out_valid_r && !$past(out_valid_r), $past(state_r == hrbd_pkg::ST_DONE), "output request raised outside the done state")
  `HRBD_ASSERT_NEVER(a_slot_range, slot_r > SLOT_W'(HISTORY_DEPTH - 1), "history slot out of range")
  `HRBD_ASSERT_IMPL(a_divisor_nonzero, (state_r == hrbd_pkg::ST_DIV_RATE) || (state_r == hrbd_pkg::ST_DIV_AVG), dvs_r != '0, "divider running with a zero divisor")
  `HRBD_ASSERT_IMPL(a_stall_while_busy, state_r != hrbd_pkg::ST_IDLE, in_stall, "sample accepted while a previous one is in work")

endmodule
